// ===== rtl/core/hist2d_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hist2d_pkg
// Shared types, sizes and codes of the two-dimensional histogram binner.
// ---------------------------------------------------------------------------
package hist2d_pkg;

  // store geometry
  localparam int MAX_BINS_X  = 64;
  localparam int MAX_BINS_Y  = 64;
  localparam int COUNT_WIDTH = 32;
  localparam int STORE_DEPTH = MAX_BINS_X * MAX_BINS_Y;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int BX_W        = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
  localparam int BY_W        = (MAX_BINS_Y > 1) ? $clog2(MAX_BINS_Y) : 1;
  localparam int NBX_W       = $clog2(MAX_BINS_X + 1);
  localparam int NBY_W       = $clog2(MAX_BINS_Y + 1);
  localparam int BIN_W       = (BX_W > BY_W) ? BX_W : BY_W;
  localparam int NB_W        = (NBX_W > NBY_W) ? NBX_W : NBY_W;

  // fixed field widths
  localparam int SAMPLE_W    = 32;
  localparam int BINS_W      = 7;
  localparam int STATUS_W    = 2;
  localparam int BIN_INDEX_W = 12;
  localparam int BIN_COUNT_W = 32;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  // multiplier split: 16 x 32 partial products
  localparam int HALF_W = SAMPLE_W / 2;
  localparam int PROD_W = HALF_W + SAMPLE_W;
  localparam int SUM_W  = 2 * SAMPLE_W;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X       = 4'd0,
    REG_MIN_Y       = 4'd1,
    REG_INV_BIN_X   = 4'd2,
    REG_INV_BIN_Y   = 4'd3,
    REG_BINS_X      = 4'd4,
    REG_BINS_Y      = 4'd5,
    REG_EDGE_MODE_X = 4'd6,
    REG_EDGE_MODE_Y = 4'd7
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_COUNTED = 2'd0,
    ST_DISC_X  = 2'd1,
    ST_DISC_Y  = 2'd2
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/hist2d_in_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hist2d_in_if
// Sample channel: one (x, y) pair per beat.
// ---------------------------------------------------------------------------
interface hist2d_in_if
  import hist2d_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_x;
  logic signed [SAMPLE_W-1:0] sample_y;

  modport source (output valid, output sample_x, output sample_y, input ready);
  modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/hist2d_out_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hist2d_out_if
// Result channel: status, bin index and updated count per beat.
// ---------------------------------------------------------------------------
interface hist2d_out_if
  import hist2d_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [BIN_INDEX_W-1:0] bin_index;
  logic [BIN_COUNT_W-1:0] bin_count;

  modport source (output valid, output status, output bin_index, output bin_count,
                  input ready);
  modport sink   (input valid, input status, input bin_index, input bin_count,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/hist2d_cfg_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hist2d_cfg_if
// Register write channel: index and data per beat.
// ---------------------------------------------------------------------------
interface hist2d_cfg_if
  import hist2d_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/histogram_2d_binner_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// histogram_2d_binner_core
// Bins (x, y) Q16.16 samples and bumps a saturating counter per bin.
// ---------------------------------------------------------------------------
// Sequence: a counted sample steps through MX0, MX1, MY0, MY1, QY, IDX, RD, INC
//   and RES; one discarded on x goes from MY0 to RES, one discarded on y from QY.
// Samples do not overlap: a new one is taken only back in IDLE. The order is
//   set by the shared 16x32 multiplier (four partial products) and the count RAM's
//   read-then-write on a single port pair.
// Reset: synchronous; then a sweep zeroes every count RAM entry, during
//   which no sample is taken (register writes are taken throughout).
module histogram_2d_binner_core
  import hist2d_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  hist2d_in_if.sink   in_bus,
  hist2d_out_if.source out_bus,
  hist2d_cfg_if.sink  cfg_bus
);

  localparam int IDXF_W = BY_W + NBX_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MX0,
    S_MX1,
    S_MY0,
    S_MY1,
    S_QY,
    S_IDX,
    S_RD,
    S_INC,
    S_RES
  } state_t;

  // configuration
  logic [SAMPLE_W-1:0] min_x_r, min_y_r, inv_bin_x_r, inv_bin_y_r;
  logic [BINS_W-1:0]   bins_x_r, bins_y_r;
  logic                edge_mode_x_r, edge_mode_y_r;

  // control
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] clr_addr_r;
  logic             out_valid_r;

  // datapath
  logic [SAMPLE_W-1:0]    mag_x_r, mag_y_r;
  logic                   neg_x_r, neg_y_r;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [PROD_W-1:0]      acc_r;
  logic [BX_W-1:0]        bx_r;
  logic [BY_W-1:0]        by_r;
  logic [IDX_W-1:0]       idx_r;
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic [STATUS_W-1:0]    res_status_r;
  logic [IDX_W-1:0]       res_idx_r;
  logic [COUNT_WIDTH-1:0] res_cnt_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [BIN_INDEX_W-1:0] out_index_r;
  logic [BIN_COUNT_W-1:0] out_count_r;

  // count store
  logic [COUNT_WIDTH-1:0] mem [STORE_DEPTH];
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  // combinational helpers
  logic                       in_fire, cfg_fire, out_free;
  logic signed [SAMPLE_W:0]   diff_x, diff_y;
  logic [SAMPLE_W-1:0]        abs_x, abs_y;
  logic [HALF_W-1:0]          mul_a;
  logic [SAMPLE_W-1:0]        mul_b;
  logic [SUM_W-1:0]           sum;
  logic [SAMPLE_W-1:0]        q;
  logic [NBX_W-1:0]           nx;
  logic [NBY_W-1:0]           ny;
  logic [NB_W-1:0]            nb_sel;
  logic                       disc_sel, neg_sel, dec_keep;
  logic [BIN_W-1:0]           dec_bin;
  logic [IDXF_W-1:0]          idx_full;
  logic [IDX_W-1:0]           idx_clamp;
  logic [COUNT_WIDTH-1:0]     cnt_inc;

  function automatic logic [NBX_W-1:0] eff_bx(input logic [BINS_W-1:0] b);
    if (b == '0) eff_bx = NBX_W'(1);
    else if (32'(b) > 32'(MAX_BINS_X)) eff_bx = NBX_W'(MAX_BINS_X);
    else eff_bx = NBX_W'(b);
  endfunction

  function automatic logic [NBY_W-1:0] eff_by(input logic [BINS_W-1:0] b);
    if (b == '0) eff_by = NBY_W'(1);
    else if (32'(b) > 32'(MAX_BINS_Y)) eff_by = NBY_W'(MAX_BINS_Y);
    else eff_by = NBY_W'(b);
  endfunction

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign cfg_fire = cfg_bus.valid && cfg_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;

  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid     = out_valid_r;
  assign out_bus.status    = out_status_r;
  assign out_bus.bin_index = out_index_r;
  assign out_bus.bin_count = out_count_r;

  assign nx = eff_bx(bins_x_r);
  assign ny = eff_by(bins_y_r);

  // offset from the lower edge, as sign and magnitude (magnitude fits 32 bits)
  assign diff_x = {in_bus.sample_x[SAMPLE_W-1], in_bus.sample_x}
                - {min_x_r[SAMPLE_W-1], min_x_r};
  assign diff_y = {in_bus.sample_y[SAMPLE_W-1], in_bus.sample_y}
                - {min_y_r[SAMPLE_W-1], min_y_r};
  assign abs_x  = diff_x[SAMPLE_W] ? SAMPLE_W'(-diff_x) : diff_x[SAMPLE_W-1:0];
  assign abs_y  = diff_y[SAMPLE_W] ? SAMPLE_W'(-diff_y) : diff_y[SAMPLE_W-1:0];

  // shared multiplier, one half of a magnitude per cycle
  always_comb begin
    case (state_r)
      S_MX0:   begin mul_a = mag_x_r[HALF_W-1:0];        mul_b = inv_bin_x_r; end
      S_MX1:   begin mul_a = mag_x_r[SAMPLE_W-1:HALF_W]; mul_b = inv_bin_x_r; end
      S_MY0:   begin mul_a = mag_y_r[HALF_W-1:0];        mul_b = inv_bin_y_r; end
      S_MY1:   begin mul_a = mag_y_r[SAMPLE_W-1:HALF_W]; mul_b = inv_bin_y_r; end
      default: begin mul_a = '0;                         mul_b = '0;          end
    endcase
    prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // bin decision: x in S_MY0, y in S_QY
  always_comb begin
    sum = {{(SUM_W-PROD_W){1'b0}}, acc_r} + {prod_r, {HALF_W{1'b0}}};
    q   = sum[SUM_W-1:SAMPLE_W];
    if (state_r == S_MY0) begin
      nb_sel   = NB_W'(nx);
      disc_sel = edge_mode_x_r;
      neg_sel  = neg_x_r;
    end else begin
      nb_sel   = NB_W'(ny);
      disc_sel = edge_mode_y_r;
      neg_sel  = neg_y_r;
    end
    if (neg_sel && q != '0) begin
      dec_keep = !disc_sel;
      dec_bin  = '0;
    end else if (q >= 32'(nb_sel)) begin
      dec_keep = !disc_sel;
      dec_bin  = BIN_W'(nb_sel - NB_W'(1));
    end else begin
      dec_keep = 1'b1;
      dec_bin  = BIN_W'(q);
    end
  end

  // row-major index
  always_comb begin
    idx_full = IDXF_W'(by_r) * IDXF_W'(nx) + IDXF_W'(bx_r);
    if (32'(idx_full) > 32'(STORE_DEPTH - 1)) idx_clamp = IDX_W'(STORE_DEPTH - 1);
    else idx_clamp = IDX_W'(idx_full);
  end

  assign cnt_inc = (rd_data_r == COUNT_MAX) ? rd_data_r : rd_data_r + COUNT_WIDTH'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = cnt_inc;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (state_r == S_INC) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[idx_r];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_addr_r == IDX_W'(STORE_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_fire) state_nxt = S_MX0;
      S_MX0:   state_nxt = S_MX1;
      S_MX1:   state_nxt = S_MY0;
      S_MY0:   state_nxt = dec_keep ? S_MY1 : S_RES;
      S_MY1:   state_nxt = S_QY;
      S_QY:    state_nxt = dec_keep ? S_IDX : S_RES;
      S_IDX:   state_nxt = S_RD;
      S_RD:    state_nxt = S_INC;
      S_INC:   state_nxt = S_RES;
      S_RES:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_addr_r <= clr_addr_r + IDX_W'(1);
      if (state_r == S_RES && out_free) out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r       <= '0;
      min_y_r       <= '0;
      inv_bin_x_r   <= SAMPLE_W'(65536);
      inv_bin_y_r   <= SAMPLE_W'(65536);
      bins_x_r      <= BINS_W'(64);
      bins_y_r      <= BINS_W'(64);
      edge_mode_x_r <= 1'b0;
      edge_mode_y_r <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_reg_t'(cfg_bus.index))
        REG_MIN_X:       min_x_r       <= cfg_bus.data;
        REG_MIN_Y:       min_y_r       <= cfg_bus.data;
        REG_INV_BIN_X:   inv_bin_x_r   <= cfg_bus.data;
        REG_INV_BIN_Y:   inv_bin_y_r   <= cfg_bus.data;
        REG_BINS_X:      bins_x_r      <= cfg_bus.data[BINS_W-1:0];
        REG_BINS_Y:      bins_y_r      <= cfg_bus.data[BINS_W-1:0];
        REG_EDGE_MODE_X: edge_mode_x_r <= cfg_bus.data[0];
        REG_EDGE_MODE_Y: edge_mode_y_r <= cfg_bus.data[0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mag_x_r <= abs_x;
      mag_y_r <= abs_y;
      neg_x_r <= diff_x[SAMPLE_W];
      neg_y_r <= diff_y[SAMPLE_W];
    end
    prod_r <= prod_nxt;
    if (state_r == S_MX1 || state_r == S_MY1) acc_r <= prod_r;
    case (state_r)
      S_MY0: begin
        bx_r <= BX_W'(dec_bin);
        if (!dec_keep) begin
          res_status_r <= ST_DISC_X;
          res_idx_r    <= '0;
          res_cnt_r    <= '0;
        end
      end
      S_QY: begin
        by_r <= BY_W'(dec_bin);
        if (!dec_keep) begin
          res_status_r <= ST_DISC_Y;
          res_idx_r    <= '0;
          res_cnt_r    <= '0;
        end
      end
      S_IDX: idx_r <= idx_clamp;
      S_INC: begin
        res_status_r <= ST_COUNTED;
        res_idx_r    <= idx_r;
        res_cnt_r    <= cnt_inc;
      end
      default: ;
    endcase
    if (state_r == S_RES && out_free) begin
      out_status_r <= res_status_r;
      out_index_r  <= BIN_INDEX_W'(res_idx_r);
      out_count_r  <= BIN_COUNT_W'(res_cnt_r);
    end
  end

`ifndef SYNTHESIS
  a_no_sample_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_bus.ready)
    else $error("sample taken during count store clear");

  a_count_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INC |-> mem_wdata >= rd_data_r && mem_wdata != '0)
    else $error("counter update went backward or wrapped");

  a_result_from_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RES))
    else $error("result beat raised outside result state");

  a_discard_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MY0 || state_r == S_QY) && !dec_keep |=> !mem_we)
    else $error("count store written for a discarded sample");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_histogram_2d_binner_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_histogram_2d_binner_core
// Streams Q16.16 (x, y) samples through the 2-D histogram binner under
// several register settings and handshake pacing. It keeps its own bin
// tallies and compares every result beat in order against them.
// ---------------------------------------------------------------------------
import hist2d_pkg::*;

typedef struct packed {
  status_t                status;
  logic [BIN_INDEX_W-1:0] bin_index;
  logic [BIN_COUNT_W-1:0] bin_count;
} bin_result_t;

class hist_scoreboard;
  logic [SAMPLE_W-1:0]    min_x, min_y, inv_x, inv_y;
  logic [BINS_W-1:0]      bins_x, bins_y;
  bit                     discard_x, discard_y;
  logic [COUNT_WIDTH-1:0] tally [STORE_DEPTH];
  bin_result_t            expected_q [$];
  int                     errors;

  function new();
    min_x     = '0;
    min_y     = '0;
    inv_x     = 32'h0001_0000;
    inv_y     = 32'h0001_0000;
    bins_x    = 7'd64;
    bins_y    = 7'd64;
    discard_x = 1'b0;
    discard_y = 1'b0;
    errors    = 0;
    foreach (tally[i]) tally[i] = '0;
  endfunction

  task report(string msg);
    if (errors < 40) $display("[%0t] MISMATCH %s", $time, msg);
    errors++;
  endtask

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_MIN_X:       min_x = d;
      REG_MIN_Y:       min_y = d;
      REG_INV_BIN_X:   inv_x = d;
      REG_INV_BIN_Y:   inv_y = d;
      REG_BINS_X:      bins_x = d[BINS_W-1:0];
      REG_BINS_Y:      bins_y = d[BINS_W-1:0];
      REG_EDGE_MODE_X: discard_x = d[0];
      REG_EDGE_MODE_Y: discard_y = d[0];
      default: ;
    endcase
  endfunction

  // 0 behaves as 1, anything past the axis maximum as that maximum
  function int unsigned eff_bins(logic [BINS_W-1:0] b, int unsigned lim);
    if (b == 0) return 1;
    return (b > lim) ? lim : b;
  endfunction

  // returns 0 when the sample is dropped on this axis
  function bit bin_axis(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] mn,
                        logic [SAMPLE_W-1:0] inv, int unsigned nb, bit disc,
                        output int unsigned bin);
    longint          diff;
    longint unsigned mag, q;
    diff = longint'($signed(s)) - longint'($signed(mn));
    mag  = (diff < 0) ? -diff : diff;
    q    = (mag * {32'd0, inv}) >> 32;
    bin  = 0;
    // below the edge by less than one bin truncates to bin 0 and stays
    if (diff < 0 && q != 0) begin
      if (disc) return 0;
      return 1;
    end
    if (q >= nb) begin
      if (disc) return 0;
      bin = nb - 1;
      return 1;
    end
    bin = q[31:0];
    return 1;
  endfunction

  function void note_sample(logic [SAMPLE_W-1:0] sx, logic [SAMPLE_W-1:0] sy);
    int unsigned nx, ny, bx, by, idx;
    bin_result_t r;
    nx = eff_bins(bins_x, MAX_BINS_X);
    ny = eff_bins(bins_y, MAX_BINS_Y);
    r  = '0;
    if (!bin_axis(sx, min_x, inv_x, nx, discard_x, bx)) begin
      r.status = ST_DISC_X;
    end else if (!bin_axis(sy, min_y, inv_y, ny, discard_y, by)) begin
      r.status = ST_DISC_Y;
    end else begin
      idx = by * nx + bx;
      if (idx >= STORE_DEPTH) idx = STORE_DEPTH - 1;
      if (tally[idx] != COUNT_MAX) tally[idx] = tally[idx] + 1'b1;
      r.status    = ST_COUNTED;
      r.bin_index = idx[BIN_INDEX_W-1:0];
      r.bin_count = tally[idx];
    end
    expected_q.push_back(r);
  endfunction

  task check_result(logic [STATUS_W-1:0] st, logic [BIN_INDEX_W-1:0] bi,
                    logic [BIN_COUNT_W-1:0] bc);
    bin_result_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected beat status=%0d index=%0d count=%0d", st, bi, bc));
      return;
    end
    e = expected_q.pop_front();
    if (st !== e.status || bi !== e.bin_index || bc !== e.bin_count)
      report($sformatf("status=%0d index=%0d count=%0d, want %0d/%0d/%0d",
                       st, bi, bc, e.status, e.bin_index, e.bin_count));
  endtask

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_histogram_2d_binner_core;

  localparam int Q16_ONE         = 65536;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_CYCLES     = 400;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int HOLD_PHASE      = 4;
  localparam int PAUSE_PHASE     = 5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  logic clk = 1'b0;
  logic rst_n;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  bit   hold_req  = 1'b0;
  int   hold_left = 0;

  hist_scoreboard sb = new();

  hist2d_in_if  in_if ();
  hist2d_out_if out_if ();
  hist2d_cfg_if cfg_if ();

  histogram_2d_binner_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  always #5 clk = ~clk;

  // watchdog; its limit is far above the expected run incl. the post-reset clear
  initial begin
    #3_000_000;
    $display("histogram_2d_binner_core verification failed");
    $finish;
  end

  // result side: random stalls, or a long hold when asked
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
        sb.note_sample(in_if.sample_x, in_if.sample_y);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_result(out_if.status, out_if.bin_index, out_if.bin_count);
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] sx, input logic [SAMPLE_W-1:0] sy);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid    <= 1'b1;
    in_if.sample_x <= sx;
    in_if.sample_y <= sy;
    do @(posedge clk); while (in_if.ready !== 1'b1);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    stop_sending();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_pacing(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 87; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 87; end
      default: begin idle_pct = 25; stall_pct = 25; end
    endcase
  endtask

  // mostly near the histogram window so bins fill up, some raw noise
  function automatic logic [SAMPLE_W-1:0] pick_coord(logic [SAMPLE_W-1:0] mn,
                                                    logic [SAMPLE_W-1:0] inv,
                                                    int unsigned nb);
    longint unsigned span;
    longint          offset;
    if ($urandom_range(99) < 15) return $urandom;
    if (inv == 0) span = 64'd1 << 20;
    else span = ((64'(nb) + 64'd2) << 32) / {32'd0, inv};
    if (span > 64'h7fff_ffff) span = 64'h7fff_ffff;
    offset = longint'($urandom_range(0, 32'(span))) - longint'(span >> 3);
    return mn + offset[SAMPLE_W-1:0];
  endfunction

  task automatic randomize_regs();
    logic [SAMPLE_W-1:0] mn  [2];
    logic [SAMPLE_W-1:0] inv [2];
    logic [BINS_W-1:0]   nb  [2];
    int                  r;
    for (int a = 0; a < 2; a++) begin
      r = $urandom_range(9);
      mn[a] = (r < 8) ? $urandom_range(0, 1 << 24) - (1 << 23) : $urandom;
      r = $urandom_range(9);
      if (r == 0)     inv[a] = '0;
      else if (r == 1) inv[a] = $urandom;
      else if (r < 5)  inv[a] = Q16_ONE;
      else             inv[a] = $urandom_range(1 << 12, 1 << 21);
      r = $urandom_range(9);
      if (r == 0)      nb[a] = '0;
      else if (r == 1) nb[a] = BINS_W'($urandom_range(MAX_BINS_X + 1, 127));
      else if (r < 6)  nb[a] = BINS_W'($urandom_range(1, 8));
      else             nb[a] = BINS_W'($urandom_range(1, 64));
    end
    cfg_write(REG_MIN_X, mn[0]);
    cfg_write(REG_MIN_Y, mn[1]);
    cfg_write(REG_INV_BIN_X, inv[0]);
    cfg_write(REG_INV_BIN_Y, inv[1]);
    // upper data bits are don't-care for the narrow registers
    cfg_write(REG_BINS_X, ($urandom & ~32'h7f) | nb[0]);
    cfg_write(REG_BINS_Y, ($urandom & ~32'h7f) | nb[1]);
    cfg_write(REG_EDGE_MODE_X, $urandom);
    cfg_write(REG_EDGE_MODE_Y, $urandom);
    if ($urandom_range(3) == 0)
      cfg_write(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
  endtask

  task automatic run_random_phase(input int p);
    int unsigned nx, ny;
    set_pacing(p % 4);
    randomize_regs();
    nx = sb.eff_bins(sb.bins_x, MAX_BINS_X);
    ny = sb.eff_bins(sb.bins_y, MAX_BINS_Y);
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      send_sample(pick_coord(sb.min_x, sb.inv_x, nx), pick_coord(sb.min_y, sb.inv_y, ny));
      // hold phase: result side backs up while samples keep coming; pause phase drains midway
      if (p == HOLD_PHASE && i == 0) hold_req = 1'b1;
      if (p == PAUSE_PHASE && i == ITEMS_PER_PHASE / 2) begin
        stop_sending();
        wait_results();
      end
    end
    settle();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.sample_x = '0;
    in_if.sample_y = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: unit bins, 64 x 64, clamping; repeats hit one bin back to back
    set_pacing(0);
    send_sample(0, 0);
    send_sample(0, 0);
    send_sample(0, 0);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff);
    send_sample(32'h8000_0000, 32'h8000_0000);
    send_sample(-1, -1);
    send_sample(Q16_ONE, 0);
    send_sample(0, Q16_ONE);
    send_sample(63 * Q16_ONE, 63 * Q16_ONE);
    send_sample(64 * Q16_ONE, Q16_ONE);
    settle();

    // discard on both axes, 10 x 4 bins, half and double bin widths
    cfg_write(REG_MIN_X, -5 * Q16_ONE);
    cfg_write(REG_MIN_Y, 3 * Q16_ONE);
    cfg_write(REG_INV_BIN_X, 2 * Q16_ONE);
    cfg_write(REG_INV_BIN_Y, Q16_ONE / 2);
    cfg_write(REG_BINS_X, 10);
    cfg_write(REG_BINS_Y, 4);
    cfg_write(REG_EDGE_MODE_X, 1);
    cfg_write(REG_EDGE_MODE_Y, 1);
    send_sample(-5 * Q16_ONE, 3 * Q16_ONE);
    send_sample(-5 * Q16_ONE - 1, 3 * Q16_ONE);
    send_sample(-6 * Q16_ONE, 3 * Q16_ONE);
    send_sample(0, 3 * Q16_ONE);
    send_sample(-1, 3 * Q16_ONE + 1);
    send_sample(-5 * Q16_ONE, 11 * Q16_ONE);
    send_sample(-7 * Q16_ONE, 100 * Q16_ONE);
    send_sample(-5 * Q16_ONE, 3 * Q16_ONE - 1);
    send_sample(-4 * Q16_ONE, 0);
    send_sample(-3 * Q16_ONE, 10 * Q16_ONE + Q16_ONE / 2);
    settle();

    // register extremes: zero and oversized bin counts, full and zero scale
    set_pacing(3);
    cfg_write(REG_MIN_X, 32'h8000_0000);
    cfg_write(REG_MIN_Y, 32'h7fff_ffff);
    cfg_write(REG_INV_BIN_X, 32'hffff_ffff);
    cfg_write(REG_INV_BIN_Y, 32'h0000_0000);
    cfg_write(REG_BINS_X, 0);
    cfg_write(REG_BINS_Y, 127);
    cfg_write(REG_EDGE_MODE_X, 0);
    cfg_write(REG_EDGE_MODE_Y, 1);
    cfg_write(REG_UNUSED_LO, $urandom);
    cfg_write(REG_UNUSED_HI, $urandom);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff);
    send_sample(32'h8000_0000, 32'h8000_0000);
    send_sample(0, 0);
    send_sample($urandom, $urandom);
    send_sample($urandom, $urandom);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase(p);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("histogram_2d_binner_core verification clean");
    end else begin
      $display("histogram_2d_binner_core verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/hist2d_pkg.sv
rtl/core/hist2d_in_if.sv
rtl/core/hist2d_out_if.sv
rtl/core/hist2d_cfg_if.sv
rtl/core/histogram_2d_binner_core.sv
bench/tb_histogram_2d_binner_core.sv
